[hw/rtl/impulse_collision_response_defines.svh]
// Assertion helpers used by icr_apply in the collision response block.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef IMPULSE_COLLISION_RESPONSE_DEFINES_SVH
`define IMPULSE_COLLISION_RESPONSE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ICR_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ICR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[hw/rtl/icr_pkg.sv]
package icr_pkg;

  // Fixed field widths of the contact and result transfers.
  localparam int unsigned VecW  = 63;
  localparam int unsigned MassW = 32;
  localparam int unsigned RestW = 17;

  // Fixed-point formats.
  localparam int unsigned CompBitsDef = 21;
  localparam int unsigned VelFrac     = 10;
  localparam int unsigned JFrac       = 20;
  localparam int unsigned WFrac       = 24;
  localparam int unsigned RestOne     = 65536;

  // The mass share divider resolves one quotient bit per stage.
  localparam int unsigned DivSteps = WFrac;

  typedef struct packed {
    logic [VecW-1:0]  velocity_a;
    logic [VecW-1:0]  velocity_b;
    logic [VecW-1:0]  contact_normal;
    logic [MassW-1:0] mass_a;
    logic [MassW-1:0] mass_b;
    logic [RestW-1:0] restitution_a;
    logic [RestW-1:0] restitution_b;
    logic             static_a;
    logic             static_b;
  } icr_in_t;

  typedef struct packed {
    logic [VecW-1:0] new_velocity_a;
    logic [VecW-1:0] new_velocity_b;
    logic            resolved;
  } icr_out_t;

  // Mass share of body A and whether the division left a remainder.
  typedef struct packed {
    logic [WFrac-1:0] w;
    logic             rem_nz;
  } icr_wt_t;

endpackage

[hw/rtl/impulse_collision_response.sv]
// Impulse collision response: one contact in, both updated velocities out.
// Pipeline: 25 divider stages for the mass share, 5 for the impulse, 5 for applying it.
// Throughput: one contact per cycle; the whole pipeline holds while a result waits.
// Reset (asynchronous, active low) clears all valid bits; data registers are not reset.
module impulse_collision_response
  import icr_pkg::*;
#(
  parameter int unsigned ComponentBits = CompBitsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  icr_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output icr_out_t out_data_o
);

  logic                      en;
  logic                      div_valid;
  icr_in_t                   div_data;
  icr_wt_t                   div_wt;
  logic                      dot_valid;
  icr_in_t                   dot_data;
  icr_wt_t                   dot_wt;
  logic                      dot_skip;
  logic [ComponentBits+13:0] dot_j;

  // All stages advance together unless a result is held at the output.
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  icr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (div_valid),
    .data_o  (div_data),
    .wt_o    (div_wt)
  );

  icr_dot #(
    .ComponentBits (ComponentBits)
  ) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .data_i  (div_data),
    .wt_i    (div_wt),
    .valid_o (dot_valid),
    .data_o  (dot_data),
    .wt_o    (dot_wt),
    .skip_o  (dot_skip),
    .j_o     (dot_j)
  );

  icr_apply #(
    .ComponentBits (ComponentBits)
  ) u_apply (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .data_i  (dot_data),
    .wt_i    (dot_wt),
    .skip_i  (dot_skip),
    .j_i     (dot_j),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

endmodule

[hw/rtl/icr_div.sv]
module icr_div
  import icr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  icr_in_t data_i,
  output logic    valid_o,
  output icr_in_t data_o,
  output icr_wt_t wt_o
);

  localparam int unsigned SumW = MassW + 1;
  localparam int unsigned RemW = MassW + 2;

  logic [DivSteps:0] v_q;
  icr_in_t           data_q [DivSteps+1];
  logic [SumW-1:0]   sum_q  [DivSteps+1];
  logic [RemW-1:0]   rem_q  [DivSteps+1];
  logic [WFrac-1:0]  quo_q  [DivSteps+1];
  logic [RemW-1:0]   shl    [DivSteps+1];
  logic              ge     [DivSteps+1];
  logic [MassW-1:0]  ma;
  logic [MassW-1:0]  mb;

  // A zero mass counts as the smallest step.
  assign ma = (data_i.mass_a == '0) ? MassW'(1) : data_i.mass_a;
  assign mb = (data_i.mass_b == '0) ? MassW'(1) : data_i.mass_b;

  // Restoring division step: doubled remainder against the mass sum.
  always_comb begin
    shl[0] = '0;
    ge[0]  = 1'b0;
    for (int k = 1; k <= DivSteps; k++) begin
      shl[k] = {rem_q[k-1][RemW-2:0], 1'b0};
      ge[k]  = shl[k] >= RemW'(sum_q[k-1]);
    end
  end

  // Valid bits move with the stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivSteps-1:0], valid_i};
    end
  end

  // Stage 0 loads mB as partial remainder; each later stage yields one quotient bit.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      sum_q[0]  <= SumW'(ma) + SumW'(mb);
      rem_q[0]  <= RemW'(mb);
      quo_q[0]  <= '0;
      for (int k = 1; k <= DivSteps; k++) begin
        data_q[k] <= data_q[k-1];
        sum_q[k]  <= sum_q[k-1];
        rem_q[k]  <= ge[k] ? (shl[k] - RemW'(sum_q[k-1])) : shl[k];
        quo_q[k]  <= {quo_q[k-1][WFrac-2:0], ge[k]};
      end
    end
  end

  assign valid_o     = v_q[DivSteps];
  assign data_o      = data_q[DivSteps];
  assign wt_o.w      = quo_q[DivSteps];
  assign wt_o.rem_nz = |rem_q[DivSteps];

endmodule

[hw/rtl/icr_dot.sv]
module icr_dot
  import icr_pkg::*;
#(
  parameter int unsigned ComponentBits = CompBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  icr_in_t                     data_i,
  input  icr_wt_t                     wt_i,
  output logic                        valid_o,
  output icr_in_t                     data_o,
  output icr_wt_t                     wt_o,
  output logic                        skip_o,
  output logic [ComponentBits+13:0]   j_o
);

  localparam int unsigned CW     = ComponentBits;
  localparam int unsigned DW     = CW + 1;
  localparam int unsigned PW     = 2 * CW + 1;
  localparam int unsigned SW     = 2 * CW + 3;
  localparam int unsigned NVW    = 2 * CW + 1;
  localparam int unsigned MW     = RestW + 1;
  localparam int unsigned NvLoW  = CW + 1;
  localparam int unsigned NvHiW  = NVW - NvLoW;
  localparam int unsigned NumW   = 2 * CW + 18;
  localparam int unsigned JShift = CW + 4;
  localparam int unsigned JW     = NumW - JShift;

  logic [4:0]               v_q;
  icr_in_t                  data_q [5];
  icr_wt_t                  wt_q   [5];
  logic [4:2]               skip_q;
  logic signed [CW-1:0]     va_c [3];
  logic signed [CW-1:0]     vb_c [3];
  logic signed [CW-1:0]     n_c  [3];
  logic signed [DW-1:0]     d_q  [3];
  logic signed [CW-1:0]     n_q  [3];
  logic signed [PW-1:0]     p_q  [3];
  logic signed [SW-1:0]     vn_d;
  logic signed [SW-1:0]     nvf;
  logic                     skip_d;
  logic [RestW-1:0]         emin;
  logic [RestW-1:0]         e_d;
  logic [NVW-1:0]           nv_q;
  logic [MW-1:0]            m_q;
  logic [NvLoW+MW-1:0]      lo_q;
  logic [NvHiW+MW-1:0]      hi_q;
  logic [NumW-1:0]          num;
  logic [JW-1:0]            j_q;

  // Unpack the vector components.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va_c[k] = data_i.velocity_a[k*CW +: CW];
      vb_c[k] = data_i.velocity_b[k*CW +: CW];
      n_c[k]  = data_i.contact_normal[k*CW +: CW];
    end
  end

  // Normal speed, separation test and restitution factor.
  always_comb begin
    vn_d   = SW'(p_q[0]) + SW'(p_q[1]) + SW'(p_q[2]);
    nvf    = -vn_d;
    skip_d = (data_q[1].static_a && data_q[1].static_b) ||
             (!vn_d[SW-1] && (vn_d != '0));
    emin   = (data_q[1].restitution_a < data_q[1].restitution_b) ?
             data_q[1].restitution_a : data_q[1].restitution_b;
    e_d    = (emin > RestW'(RestOne)) ? RestW'(RestOne) : emin;
  end

  assign num = (NumW'(hi_q) << NvLoW) + NumW'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      wt_q[0]   <= wt_i;
      for (int s = 1; s < 5; s++) begin
        data_q[s] <= data_q[s-1];
        wt_q[s]   <= wt_q[s-1];
      end
      // Stage 0: velocity differences.
      for (int k = 0; k < 3; k++) begin
        d_q[k] <= DW'(vb_c[k]) - DW'(va_c[k]);
        n_q[k] <= n_c[k];
      end
      // Stage 1: per-axis products.
      for (int k = 0; k < 3; k++) begin
        p_q[k] <= PW'(d_q[k]) * PW'(n_q[k]);
      end
      // Stage 2: approach speed and the (1 + e) factor.
      skip_q[2] <= skip_d;
      nv_q      <= nvf[NVW-1:0];
      m_q       <= MW'(RestOne) + MW'(e_d);
      // Stage 3: partial products of the impulse numerator.
      skip_q[3] <= skip_q[2];
      lo_q      <= (NvLoW+MW)'(nv_q[NvLoW-1:0]) * (NvLoW+MW)'(m_q);
      hi_q      <= (NvHiW+MW)'(nv_q[NVW-1:NvLoW]) * (NvHiW+MW)'(m_q);
      // Stage 4: impulse magnitude.
      skip_q[4] <= skip_q[3];
      j_q       <= num[NumW-1:JShift];
    end
  end

  assign valid_o = v_q[4];
  assign data_o  = data_q[4];
  assign wt_o    = wt_q[4];
  assign skip_o  = skip_q[4];
  assign j_o     = j_q;

endmodule

[hw/rtl/icr_apply.sv]
`include "impulse_collision_response_defines.svh"

module icr_apply
  import icr_pkg::*;
#(
  parameter int unsigned ComponentBits = CompBitsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  icr_in_t                   data_i,
  input  icr_wt_t                   wt_i,
  input  logic                      skip_i,
  input  logic [ComponentBits+13:0] j_i,
  output logic                      valid_o,
  output icr_out_t                  out_o
);

  localparam int unsigned CW     = ComponentBits;
  localparam int unsigned JW     = CW + 14;
  localparam int unsigned JLoW   = 18;
  localparam int unsigned JHiW   = JW - JLoW;
  localparam int unsigned PjlW   = JLoW + CW;
  localparam int unsigned PjhW   = JHiW + CW;
  localparam int unsigned BPW    = JW + CW;
  localparam int unsigned BShift = CW - 2;
  localparam int unsigned BW     = CW + 15;
  localparam int unsigned WW     = WFrac + 1;
  localparam int unsigned BLoW   = 18;
  localparam int unsigned BHiW   = BW - BLoW;
  localparam int unsigned PalW   = BLoW + WW;
  localparam int unsigned PahW   = BHiW + WW;
  localparam int unsigned QW     = BW + WW;
  localparam int unsigned DShift = WFrac + JFrac - VelFrac;
  localparam int unsigned DW     = QW - DShift;
  localparam int unsigned SumW   = DW + 2;

  localparam logic [WW-1:0]          WOne    = {1'b1, {WFrac{1'b0}}};
  localparam logic signed [SumW-1:0] SatHi   = SumW'((2 ** (CW - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo   = -SatHi - SumW'(1);
  localparam logic [VecW-1:0]        VecMask = VecW'((64'd1 << (3 * CW)) - 64'd1);

  logic [4:0]           v_q;
  icr_in_t              data_q [4];
  logic [3:0]           skip_q;
  logic [WW-1:0]        w_a_q  [2];
  logic [WW-1:0]        w_b_q  [2];
  logic [WW-1:0]        w_a_d;
  logic [WW-1:0]        w_b_d;
  logic [CW-1:0]        an     [3];
  logic [PjlW-1:0]      pjl_q  [3];
  logic [PjhW-1:0]      pjh_q  [3];
  logic [BPW-1:0]       bprod  [3];
  logic [BW-1:0]        base_q [3];
  logic [PalW-1:0]      pal_a_q [3];
  logic [PahW-1:0]      pah_a_q [3];
  logic [PalW-1:0]      pal_b_q [3];
  logic [PahW-1:0]      pah_b_q [3];
  logic [QW-1:0]        qa     [3];
  logic [QW-1:0]        qb     [3];
  logic [DW-1:0]        da_q   [3];
  logic [DW-1:0]        db_q   [3];
  icr_out_t             out_d;
  icr_out_t             out_q;

  function automatic logic signed [CW-1:0] sat(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] y;
    y = x;
    if (x > SatHi) begin
      y = SatHi;
    end else if (x < SatLo) begin
      y = SatLo;
    end
    return y[CW-1:0];
  endfunction

  // Mass shares; a static body takes no share, and a non-static partner takes all of it.
  always_comb begin
    if (data_i.static_a) begin
      w_a_d = '0;
    end else if (data_i.static_b) begin
      w_a_d = WOne;
    end else begin
      w_a_d = WW'(wt_i.w);
    end
    if (data_i.static_b) begin
      w_b_d = '0;
    end else if (data_i.static_a) begin
      w_b_d = WOne;
    end else begin
      w_b_d = WOne - WW'(wt_i.w) - WW'(wt_i.rem_nz);
    end
  end

  // Normal magnitudes and recombined products.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      an[k]    = data_i.contact_normal[k*CW+CW-1] ?
                 (~data_i.contact_normal[k*CW +: CW] + CW'(1)) :
                 data_i.contact_normal[k*CW +: CW];
      bprod[k] = (BPW'(pjh_q[k]) << JLoW) + BPW'(pjl_q[k]);
      qa[k]    = (QW'(pah_a_q[k]) << BLoW) + QW'(pal_a_q[k]);
      qb[k]    = (QW'(pah_b_q[k]) << BLoW) + QW'(pal_b_q[k]);
    end
  end

  // Apply the velocity changes with saturation.
  always_comb begin
    logic signed [SumW-1:0] va;
    logic signed [SumW-1:0] vb;
    logic signed [SumW-1:0] na;
    logic signed [SumW-1:0] nb;
    logic                   neg;
    out_d = '0;
    for (int k = 0; k < 3; k++) begin
      va  = SumW'($signed(data_q[3].velocity_a[k*CW +: CW]));
      vb  = SumW'($signed(data_q[3].velocity_b[k*CW +: CW]));
      neg = data_q[3].contact_normal[k*CW+CW-1];
      na  = neg ? (va + $signed(SumW'(da_q[k]))) : (va - $signed(SumW'(da_q[k])));
      nb  = neg ? (vb - $signed(SumW'(db_q[k]))) : (vb + $signed(SumW'(db_q[k])));
      if (skip_q[3] || data_q[3].static_a) begin
        na = va;
      end
      if (skip_q[3] || data_q[3].static_b) begin
        nb = vb;
      end
      out_d.new_velocity_a[k*CW +: CW] = sat(na);
      out_d.new_velocity_b[k*CW +: CW] = sat(nb);
    end
    out_d.resolved = !skip_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      skip_q[0] <= skip_i;
      for (int s = 1; s < 4; s++) begin
        data_q[s] <= data_q[s-1];
        skip_q[s] <= skip_q[s-1];
      end
      w_a_q[0] <= w_a_d;
      w_b_q[0] <= w_b_d;
      w_a_q[1] <= w_a_q[0];
      w_b_q[1] <= w_b_q[0];
      for (int k = 0; k < 3; k++) begin
        // Stage 0: impulse times normal magnitude, split in two halves.
        pjl_q[k]   <= PjlW'(j_i[JLoW-1:0]) * PjlW'(an[k]);
        pjh_q[k]   <= PjhW'(j_i[JW-1:JLoW]) * PjhW'(an[k]);
        // Stage 1: per-axis impulse.
        base_q[k]  <= bprod[k][BShift +: BW];
        // Stage 2: scale by each body's share.
        pal_a_q[k] <= PalW'(base_q[k][BLoW-1:0]) * PalW'(w_a_q[1]);
        pah_a_q[k] <= PahW'(base_q[k][BW-1:BLoW]) * PahW'(w_a_q[1]);
        pal_b_q[k] <= PalW'(base_q[k][BLoW-1:0]) * PalW'(w_b_q[1]);
        pah_b_q[k] <= PahW'(base_q[k][BW-1:BLoW]) * PahW'(w_b_q[1]);
        // Stage 3: velocity change magnitudes.
        da_q[k]    <= qa[k][QW-1:DShift];
        db_q[k]    <= qb[k][QW-1:DShift];
      end
      // Stage 4: result register.
      out_q <= out_d;
    end
  end

  assign valid_o = v_q[4];
  assign out_o   = out_q;

  `ICR_ASSERT_NOW(a_share_sum, v_q[0] && !data_q[0].static_a && !data_q[0].static_b, (WW+1)'(w_a_q[0]) + (WW+1)'(w_b_q[0]) >= (WW+1)'(WOne) - (WW+1)'(1), "mass shares do not add up to one")
  `ICR_ASSERT_NEXT(a_skip_unresolved, v_q[3] && en_i && skip_q[3], !out_q.resolved, "skipped contact marked resolved")
  `ICR_ASSERT_NEXT(a_static_a_keep, v_q[3] && en_i && data_q[3].static_a, out_q.new_velocity_a == $past(data_q[3].velocity_a & VecMask), "static body A changed velocity")
  `ICR_ASSERT_NEXT(a_static_b_keep, v_q[3] && en_i && data_q[3].static_b, out_q.new_velocity_b == $past(data_q[3].velocity_b & VecMask), "static body B changed velocity")

endmodule
